// File: design/es2cd_pkg.sv
`timescale 1ns / 1ps
// Package for the epoch seconds to calendar date core.
// Holds widths, constants, the back-end state type, the queue status type and the month length table.
// Used by every module of the block; depends on nothing.
package es2cd_pkg;

   localparam int LOCAL_WIDTH  = 32;
   localparam int EPOCH_WIDTH  = 31;
   localparam int ZONE_WIDTH   = 17;
   localparam int DAYS_WIDTH   = 15;
   localparam int YEAR_WIDTH   = 11;
   localparam int MONTH_WIDTH  = 4;
   localparam int DAY_WIDTH    = 5;
   localparam int HOUR_WIDTH   = 5;
   localparam int MINUTE_WIDTH = 6;
   localparam int SECOND_WIDTH = 6;
   localparam int REM_WIDTH    = 6;
   localparam int YLEN_WIDTH   = 9;

   localparam int QUEUE_DEPTH = 2;

   localparam logic signed [ZONE_WIDTH-1:0] ZONE_RESET = 17'sd28800;

   localparam logic [YEAR_WIDTH-1:0] BASE_YEAR        = 11'd1970;
   localparam logic [6:0]            BASE_YEAR_MOD100 = 7'd70;
   localparam logic [8:0]            BASE_YEAR_MOD400 = 9'd370;

   localparam logic [REM_WIDTH-1:0] SECS_PER_MIN   = 6'd60;
   localparam logic [REM_WIDTH-1:0] MINS_PER_HOUR  = 6'd60;
   localparam logic [REM_WIDTH-1:0] HOURS_PER_DAY  = 6'd24;

   // Reciprocals for division by 60 and by 24. The quotient is the product
   // shifted right; both are exact for every 32-bit dividend.
   localparam logic [LOCAL_WIDTH-1:0] DIV60_MAGIC = 32'h88888889;
   localparam int                     DIV60_SHIFT = 37;
   localparam logic [LOCAL_WIDTH-1:0] DIV24_MAGIC = 32'hAAAAAAAB;
   localparam int                     DIV24_SHIFT = 36;

   localparam logic [1:0] PASS_SEC  = 2'd0;
   localparam logic [1:0] PASS_MIN  = 2'd1;
   localparam logic [1:0] PASS_HOUR = 2'd2;

   localparam logic [MONTH_WIDTH-1:0] MONTH_FEB = 4'd1;
   localparam logic [MONTH_WIDTH-1:0] MONTH_DEC = 4'd11;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_YEAR,
      ST_MONTH,
      ST_OUT
   } back_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   // Days in a month, counted from 0 for January.
   function automatic logic [DAY_WIDTH-1:0] month_length(
      input logic [MONTH_WIDTH-1:0] month,
      input logic                   leap
   );
      logic [DAY_WIDTH-1:0] len;
      begin
         case (month)
            MONTH_FEB:              len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
            default:                len = 5'd31;
         endcase
         return len;
      end
   endfunction

endpackage

// File: design/es2cd_front.sv
`timescale 1ns / 1ps
// Front end: holds the time-zone register, accepts input words, applies the
// offset with saturation at zero and hands the local second count to the queue.
// Depends on es2cd_pkg.
module es2cd_front (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       push,
   output logic                                       full,
   input  logic [es2cd_pkg::EPOCH_WIDTH-1:0]          req_epoch_seconds,
   input  logic                                       csr_write_enable,
   input  logic [es2cd_pkg::ZONE_WIDTH-1:0]           csr_write_data,
   input  es2cd_pkg::fifo_status_type                 fifo_status,
   output logic                                       fifo_push,
   output logic [es2cd_pkg::LOCAL_WIDTH-1:0]          fifo_data
);

   logic signed [es2cd_pkg::ZONE_WIDTH-1:0]  zone_ff, zone_in;
   logic [es2cd_pkg::LOCAL_WIDTH-1:0]        local_ff, local_in;
   logic                                     valid_ff, valid_in;
   logic                                     accept;
   logic signed [es2cd_pkg::LOCAL_WIDTH:0]   sum;

   assign sum = $signed({2'b00, req_epoch_seconds}) + (es2cd_pkg::LOCAL_WIDTH + 1)'(zone_ff);

   assign full      = valid_ff & fifo_status.full;
   assign accept    = push & ~full;
   assign fifo_push = valid_ff & ~fifo_status.full;
   assign fifo_data = local_ff;

   always_comb begin
      zone_in  = csr_write_enable ? $signed(csr_write_data) : zone_ff;
      valid_in = accept | (valid_ff & fifo_status.full);
      local_in = local_ff;
      if (accept) begin
         // A local time before the epoch saturates to the epoch itself.
         local_in = sum[es2cd_pkg::LOCAL_WIDTH] ? '0 : sum[es2cd_pkg::LOCAL_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff  <= es2cd_pkg::ZONE_RESET;
         valid_ff <= 1'b0;
      end else begin
         zone_ff  <= zone_in;
         valid_ff <= valid_in;
      end
      local_ff <= local_in;
   end

endmodule

// File: design/es2cd_fifo.sv
`timescale 1ns / 1ps
// Short queue of local second counts between the front and back ends.
// Depends on es2cd_pkg for the status struct.
module es2cd_fifo #(
   parameter int Depth = es2cd_pkg::QUEUE_DEPTH,
   parameter int Width = es2cd_pkg::LOCAL_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [Width-1:0]            push_data,
   input  logic                        pop,
   output logic [Width-1:0]            pop_data,
   output es2cd_pkg::fifo_status_type  status
);

   localparam int PtrWidth   = $clog2(Depth);
   localparam int CountWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0]   LastPtr  = PtrWidth'(Depth - 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(Depth);

   logic [Width-1:0]      store_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign status.full  = (count_ff == FullCount);
   assign status.empty = (count_ff == '0);
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & ~status.empty;
   assign pop_data     = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: design/es2cd_back.sv
`timescale 1ns / 1ps
// Back end: splits a local second count by reciprocal multiplication, walks years
// and months from 1970, and holds the finished result word for the reader.
// Depends on es2cd_pkg.
module es2cd_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  es2cd_pkg::fifo_status_type             fifo_status,
   input  logic [es2cd_pkg::LOCAL_WIDTH-1:0]      fifo_data,
   output logic                                   fifo_pop,
   output logic                                   empty,
   input  logic                                   pop,
   output logic [es2cd_pkg::YEAR_WIDTH-1:0]       rsp_year,
   output logic [es2cd_pkg::MONTH_WIDTH-1:0]      rsp_month,
   output logic [es2cd_pkg::DAY_WIDTH-1:0]        rsp_day_of_month,
   output logic [es2cd_pkg::HOUR_WIDTH-1:0]       rsp_hour,
   output logic [es2cd_pkg::MINUTE_WIDTH-1:0]     rsp_minute,
   output logic [es2cd_pkg::SECOND_WIDTH-1:0]     rsp_second
);

   localparam int LW = es2cd_pkg::LOCAL_WIDTH;
   localparam int RW = es2cd_pkg::REM_WIDTH;
   localparam int PW = 2 * LW;

   es2cd_pkg::back_state_type state_ff, state_in;

   logic [LW-1:0]                       num_ff, num_in;
   logic [LW-1:0]                       quot_ff, quot_in;
   logic                                phase_ff, phase_in;
   logic [1:0]                          pass_ff, pass_in;
   logic [RW-1:0]                       sec_ff, sec_in;
   logic [RW-1:0]                       min_ff, min_in;
   logic [RW-1:0]                       hour_ff, hour_in;
   logic [es2cd_pkg::DAYS_WIDTH-1:0]    days_ff, days_in;
   logic [es2cd_pkg::YEAR_WIDTH-1:0]    year_ff, year_in;
   logic [6:0]                          mod100_ff, mod100_in;
   logic [8:0]                          mod400_ff, mod400_in;
   logic [es2cd_pkg::MONTH_WIDTH-1:0]   month_ff, month_in;
   logic                                out_valid_ff, out_valid_in;
   logic                                load_out;

   logic [RW-1:0]                       divisor;
   logic [LW-1:0]                       magic;
   logic [PW-1:0]                       product;
   logic [LW-1:0]                       quotient;
   logic [RW-1:0]                       remainder;
   logic                                leap;
   logic [es2cd_pkg::YLEN_WIDTH-1:0]    ylen;
   logic [es2cd_pkg::DAY_WIDTH-1:0]     mlen;

   always_comb begin
      unique case (pass_ff)
         es2cd_pkg::PASS_SEC: begin
            divisor = es2cd_pkg::SECS_PER_MIN;
            magic   = es2cd_pkg::DIV60_MAGIC;
         end
         es2cd_pkg::PASS_MIN: begin
            divisor = es2cd_pkg::MINS_PER_HOUR;
            magic   = es2cd_pkg::DIV60_MAGIC;
         end
         default: begin
            divisor = es2cd_pkg::HOURS_PER_DAY;
            magic   = es2cd_pkg::DIV24_MAGIC;
         end
      endcase
   end

   // In each pass the quotient from the reciprocal product is
   // registered first, and the remainder follows from its low bits.
   assign product   = PW'(num_ff) * PW'(magic);
   assign quotient  = (pass_ff == es2cd_pkg::PASS_HOUR) ?
                      LW'(product >> es2cd_pkg::DIV24_SHIFT) :
                      LW'(product >> es2cd_pkg::DIV60_SHIFT);
   assign remainder = RW'(num_ff[RW-1:0] - RW'(quot_ff[RW-1:0] * divisor));

   assign leap = ((year_ff[1:0] == 2'b00) && (mod100_ff != '0)) || (mod400_ff == '0);
   assign ylen = leap ? 9'd366 : 9'd365;
   assign mlen = es2cd_pkg::month_length(month_ff, leap);

   assign empty = ~out_valid_ff;

   always_comb begin
      state_in     = state_ff;
      num_in       = num_ff;
      quot_in      = quot_ff;
      phase_in     = phase_ff;
      pass_in      = pass_ff;
      sec_in       = sec_ff;
      min_in       = min_ff;
      hour_in      = hour_ff;
      days_in      = days_ff;
      year_in      = year_ff;
      mod100_in    = mod100_ff;
      mod400_in    = mod400_ff;
      month_in     = month_ff;
      fifo_pop     = 1'b0;
      load_out     = 1'b0;
      out_valid_in = out_valid_ff & ~pop;

      unique case (state_ff)
         es2cd_pkg::ST_IDLE: begin
            if (!fifo_status.empty) begin
               fifo_pop = 1'b1;
               num_in   = fifo_data;
               phase_in = 1'b0;
               pass_in  = es2cd_pkg::PASS_SEC;
               state_in = es2cd_pkg::ST_DIV;
            end
         end
         es2cd_pkg::ST_DIV: begin
            if (!phase_ff) begin
               quot_in  = quotient;
               phase_in = 1'b1;
            end else begin
               num_in   = quot_ff;
               phase_in = 1'b0;
               unique case (pass_ff)
                  es2cd_pkg::PASS_SEC: begin
                     sec_in  = remainder;
                     pass_in = es2cd_pkg::PASS_MIN;
                  end
                  es2cd_pkg::PASS_MIN: begin
                     min_in  = remainder;
                     pass_in = es2cd_pkg::PASS_HOUR;
                  end
                  default: begin
                     hour_in   = remainder;
                     days_in   = quot_ff[es2cd_pkg::DAYS_WIDTH-1:0];
                     year_in   = es2cd_pkg::BASE_YEAR;
                     mod100_in = es2cd_pkg::BASE_YEAR_MOD100;
                     mod400_in = es2cd_pkg::BASE_YEAR_MOD400;
                     state_in  = es2cd_pkg::ST_YEAR;
                  end
               endcase
            end
         end
         es2cd_pkg::ST_YEAR: begin
            if (days_ff < es2cd_pkg::DAYS_WIDTH'(ylen)) begin
               month_in = '0;
               state_in = es2cd_pkg::ST_MONTH;
            end else begin
               days_in   = days_ff - es2cd_pkg::DAYS_WIDTH'(ylen);
               year_in   = year_ff + 1'b1;
               mod100_in = (mod100_ff == 7'd99) ? '0 : mod100_ff + 1'b1;
               mod400_in = (mod400_ff == 9'd399) ? '0 : mod400_ff + 1'b1;
            end
         end
         es2cd_pkg::ST_MONTH: begin
            if ((days_ff < es2cd_pkg::DAYS_WIDTH'(mlen)) || (month_ff == es2cd_pkg::MONTH_DEC)) begin
               state_in = es2cd_pkg::ST_OUT;
            end else begin
               days_in  = days_ff - es2cd_pkg::DAYS_WIDTH'(mlen);
               month_in = month_ff + 1'b1;
            end
         end
         es2cd_pkg::ST_OUT: begin
            // Wait until the result register is free or being read this cycle.
            if (!out_valid_ff || pop) begin
               load_out     = 1'b1;
               out_valid_in = 1'b1;
               state_in     = es2cd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = es2cd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= es2cd_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      num_ff    <= num_in;
      quot_ff   <= quot_in;
      phase_ff  <= phase_in;
      pass_ff   <= pass_in;
      sec_ff    <= sec_in;
      min_ff    <= min_in;
      hour_ff   <= hour_in;
      days_ff   <= days_in;
      year_ff   <= year_in;
      mod100_ff <= mod100_in;
      mod400_ff <= mod400_in;
      month_ff  <= month_in;
      if (load_out) begin
         rsp_year         <= year_ff;
         rsp_month        <= month_ff + 1'b1;
         rsp_day_of_month <= days_ff[es2cd_pkg::DAY_WIDTH-1:0] + 1'b1;
         rsp_hour         <= hour_ff[es2cd_pkg::HOUR_WIDTH-1:0];
         rsp_minute       <= min_ff;
         rsp_second       <= sec_ff;
      end
   end

endmodule

// File: design/epoch_seconds_to_calendar_date_core.sv
`timescale 1ns / 1ps
// Epoch seconds to local calendar date and time.
// Input: write a word on req_epoch_seconds with push while full is low.
// Output: while empty is low, rsp_* hold the oldest result word; pop takes it.
// Configuration: csr_write_enable with csr_write_data sets the signed zone
// offset in seconds, added before conversion; write it only while idle.
// A local time before the epoch gives 1970-01-01 00:00:00.
// An accepted word passes the front register and the queue, then three passes
// that divide by 60, 60 and 24 with a reciprocal multiply, a walk over the
// whole years after 1970 and one over the month steps (at most 78 steps in
// all), and a load of the result register, after which empty goes low.
// The back end works on one word at a time. The front register and a short
// queue take up to QueueDepth + 1 further words while the back end is busy.
// A stalled reader holds the result register; the back end then waits with
// its next finished word, and the front fills and raises full.
// Reset clears all handshake state and sets the offset to +8 hours.
// Depends on es2cd_pkg, es2cd_front, es2cd_fifo and es2cd_back.
module epoch_seconds_to_calendar_date_core #(
   parameter int QueueDepth = es2cd_pkg::QUEUE_DEPTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   push,
   output logic                                   full,
   input  logic [es2cd_pkg::EPOCH_WIDTH-1:0]      req_epoch_seconds,
   output logic                                   empty,
   input  logic                                   pop,
   output logic [es2cd_pkg::YEAR_WIDTH-1:0]       rsp_year,
   output logic [es2cd_pkg::MONTH_WIDTH-1:0]      rsp_month,
   output logic [es2cd_pkg::DAY_WIDTH-1:0]        rsp_day_of_month,
   output logic [es2cd_pkg::HOUR_WIDTH-1:0]       rsp_hour,
   output logic [es2cd_pkg::MINUTE_WIDTH-1:0]     rsp_minute,
   output logic [es2cd_pkg::SECOND_WIDTH-1:0]     rsp_second,
   input  logic                                   csr_write_enable,
   input  logic [es2cd_pkg::ZONE_WIDTH-1:0]       csr_write_data
);

   es2cd_pkg::fifo_status_type              fifo_status;
   logic                                    fifo_push;
   logic                                    fifo_pop;
   logic [es2cd_pkg::LOCAL_WIDTH-1:0]       fifo_wdata;
   logic [es2cd_pkg::LOCAL_WIDTH-1:0]       fifo_rdata;

   es2cd_front u_front (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_epoch_seconds (req_epoch_seconds),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .fifo_status       (fifo_status),
      .fifo_push         (fifo_push),
      .fifo_data         (fifo_wdata)
   );

   es2cd_fifo #(
      .Depth (QueueDepth),
      .Width (es2cd_pkg::LOCAL_WIDTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (fifo_wdata),
      .pop       (fifo_pop),
      .pop_data  (fifo_rdata),
      .status    (fifo_status)
   );

   es2cd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .fifo_status      (fifo_status),
      .fifo_data        (fifo_rdata),
      .fifo_pop         (fifo_pop),
      .empty            (empty),
      .pop              (pop),
      .rsp_year         (rsp_year),
      .rsp_month        (rsp_month),
      .rsp_day_of_month (rsp_day_of_month),
      .rsp_hour         (rsp_hour),
      .rsp_minute       (rsp_minute),
      .rsp_second       (rsp_second)
   );

endmodule
